// ----- rtl/u8l1_pkg.sv -----
// u8l1_pkg: types, constants and decode helpers for the UTF-8 to Latin-1 stream converter.
// No dependencies; used by the channel interfaces and the top level.
package u8l1_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] seq_len_t;
    typedef logic [1:0] count_t;

    localparam byte_t SUBST_CHAR = 8'h3f;

    localparam byte_t LEAD2_MASK = 8'he0;
    localparam byte_t LEAD2_CODE = 8'hc0;
    localparam byte_t LEAD3_MASK = 8'hf0;
    localparam byte_t LEAD3_CODE = 8'he0;
    localparam byte_t LEAD4_MASK = 8'hf8;
    localparam byte_t LEAD4_CODE = 8'hf0;

    localparam seq_len_t LEN1 = 3'd1;
    localparam seq_len_t LEN2 = 3'd2;
    localparam seq_len_t LEN3 = 3'd3;
    localparam seq_len_t LEN4 = 3'd4;

    function automatic seq_len_t seq_len(input byte_t c);
        seq_len_t n;
        if ((c & LEAD2_MASK) == LEAD2_CODE)
        begin
            n = LEN2;
        end
        else if ((c & LEAD3_MASK) == LEAD3_CODE)
        begin
            n = LEN3;
        end
        else if ((c & LEAD4_MASK) == LEAD4_CODE)
        begin
            n = LEN4;
        end
        else
        begin
            n = LEN1;
        end
        return n;
    endfunction

    // code point = {b0[4:0], b1[5:0]}, fits a byte only when b0[4:2] is zero
    function automatic byte_t decode2(input byte_t b0, input byte_t b1);
        byte_t r;
        if (b0[4:2] == 3'd0)
        begin
            r = {b0[1:0], b1[5:0]};
        end
        else
        begin
            r = SUBST_CHAR;
        end
        return r;
    endfunction

    // code point = {b0[3:0], b1[5:0], b2[5:0]}
    function automatic byte_t decode3(input byte_t b0, input byte_t b1, input byte_t b2);
        byte_t r;
        if (b0[3:0] == 4'd0 && b1[5:2] == 4'd0)
        begin
            r = {b1[1:0], b2[5:0]};
        end
        else
        begin
            r = SUBST_CHAR;
        end
        return r;
    endfunction

endpackage

// ----- rtl/u8l1_in_if.sv -----
// u8l1_in_if: valid/ready channel carrying one raw UTF-8 byte per beat.
// Depends on u8l1_pkg.
interface u8l1_in_if;
    logic             valid;
    logic             ready;
    u8l1_pkg::byte_t  byte_in;
    logic             stream_last;

    modport source (output valid, output byte_in, output stream_last, input ready);
    modport sink   (input valid, input byte_in, input stream_last, output ready);
endinterface

// ----- rtl/u8l1_out_if.sv -----
// u8l1_out_if: valid/ready channel carrying one Latin-1 byte per beat.
// Depends on u8l1_pkg.
interface u8l1_out_if;
    logic             valid;
    logic             ready;
    u8l1_pkg::byte_t  latin1_char;
    logic             run_last;
    logic             stream_done;

    modport source (output valid, output latin1_char, output run_last, output stream_done,
                    input ready);
    modport sink   (input valid, input latin1_char, input run_last, input stream_done,
                    output ready);
endinterface

// ----- rtl/utf8_to_latin1_stream.sv -----
// utf8_to_latin1_stream: UTF-8 byte stream to Latin-1 byte stream converter.
// Depends on u8l1_pkg, u8l1_in_if and u8l1_out_if.
//
// One UTF-8 byte is taken per beat on byte_ch and one Latin-1 byte leaves per beat on
// char_ch. Each byte is decoded in the cycle it is accepted into a three-entry result
// buffer, so the block sustains one byte per cycle while char_ch is ready and no flush
// results wait. Bytes of an unfinished sequence give no result; the byte that completes
// a sequence gives one. When stream_last arrives mid-sequence the held bytes are flushed
// as up to three results, drained one per cycle while char_ch is ready; byte_ch is held
// off while more than one result is waiting. No clearing pass is needed after reset.
module utf8_to_latin1_stream
(
    input  logic          clk,
    input  logic          rst_n,
    u8l1_in_if.sink       byte_ch,
    u8l1_out_if.source    char_ch
);

    // sequence gathering state
    u8l1_pkg::byte_t    held_reg [3];
    u8l1_pkg::count_t   held_count_reg;
    u8l1_pkg::count_t   held_count_next;
    u8l1_pkg::seq_len_t needed_reg;
    u8l1_pkg::seq_len_t needed_next;

    // result buffer, entry 0 is the head
    u8l1_pkg::byte_t    res_char_reg [3];
    u8l1_pkg::byte_t    res_char_next [3];
    u8l1_pkg::count_t   res_cnt_reg;
    u8l1_pkg::count_t   res_cnt_next;
    logic               res_done_reg;
    logic               res_done_next;

    logic               in_fire;
    logic               out_fire;
    u8l1_pkg::byte_t    b;
    u8l1_pkg::byte_t    buf0;
    u8l1_pkg::byte_t    buf1;
    u8l1_pkg::byte_t    buf2;
    u8l1_pkg::seq_len_t needed_eff;
    logic [2:0]         cnt;
    logic               hold;
    u8l1_pkg::count_t   k;
    u8l1_pkg::byte_t    c0;
    u8l1_pkg::byte_t    c1;
    u8l1_pkg::byte_t    c2;

    assign b        = byte_ch.byte_in;
    assign out_fire = char_ch.valid && char_ch.ready;
    assign in_fire  = byte_ch.valid && byte_ch.ready;

    assign byte_ch.ready = (res_cnt_reg == 2'd0) || (res_cnt_reg == 2'd1 && char_ch.ready);

    assign char_ch.valid       = (res_cnt_reg != 2'd0);
    assign char_ch.latin1_char = res_char_reg[0];
    assign char_ch.run_last    = (res_cnt_reg == 2'd1);
    assign char_ch.stream_done = (res_cnt_reg == 2'd1) && res_done_reg;

    assign buf0       = (held_count_reg == 2'd0) ? b : held_reg[0];
    assign buf1       = (held_count_reg == 2'd1) ? b : held_reg[1];
    assign buf2       = (held_count_reg == 2'd2) ? b : held_reg[2];
    assign needed_eff = (held_count_reg == 2'd0) ? u8l1_pkg::seq_len(b) : needed_reg;
    assign cnt        = {1'b0, held_count_reg} + 3'd1;
    assign hold       = (cnt < needed_eff) && !byte_ch.stream_last;

    // decode of one accepted byte
    always_comb
    begin
        k  = 2'd1;
        c0 = buf0;
        c1 = buf1;
        c2 = buf2;
        if (hold)
        begin
            k = 2'd0;
        end
        else if (cnt < needed_eff)
        begin
            // truncated sequence at end of stream: lead raw, rest parsed greedily
            unique case (cnt)
                3'd2:
                begin
                    k = 2'd2;
                end
                3'd3:
                begin
                    if (u8l1_pkg::seq_len(buf1) == u8l1_pkg::LEN2)
                    begin
                        k  = 2'd2;
                        c1 = u8l1_pkg::decode2(buf1, buf2);
                    end
                    else
                    begin
                        k = 2'd3;
                    end
                end
                default:
                begin
                    k = 2'd1;
                end
            endcase
        end
        else
        begin
            unique case (needed_eff)
                u8l1_pkg::LEN2: c0 = u8l1_pkg::decode2(buf0, buf1);
                u8l1_pkg::LEN3: c0 = u8l1_pkg::decode3(buf0, buf1, buf2);
                u8l1_pkg::LEN4: c0 = u8l1_pkg::SUBST_CHAR;
                default:        c0 = buf0;
            endcase
        end
    end

    always_comb
    begin
        held_count_next = held_count_reg;
        needed_next     = needed_reg;
        if (in_fire)
        begin
            if (hold)
            begin
                held_count_next = cnt[1:0];
                needed_next     = needed_eff;
            end
            else
            begin
                held_count_next = 2'd0;
                needed_next     = u8l1_pkg::LEN1;
            end
        end
    end

    always_comb
    begin
        res_char_next = res_char_reg;
        res_cnt_next  = res_cnt_reg;
        res_done_next = res_done_reg;
        if (out_fire)
        begin
            res_char_next[0] = res_char_reg[1];
            res_char_next[1] = res_char_reg[2];
            res_cnt_next     = res_cnt_reg - 2'd1;
        end
        if (in_fire && k != 2'd0)
        begin
            res_char_next[0] = c0;
            res_char_next[1] = c1;
            res_char_next[2] = c2;
            res_cnt_next     = k;
            res_done_next    = byte_ch.stream_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            needed_reg     <= u8l1_pkg::LEN1;
            res_cnt_reg    <= 2'd0;
        end
        else
        begin
            held_count_reg <= held_count_next;
            needed_reg     <= needed_next;
            res_cnt_reg    <= res_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && hold)
        begin
            held_reg[held_count_reg] <= b;
        end
        res_char_reg  <= res_char_next;
        res_done_reg  <= res_done_next;
    end

    // a held sequence never reaches three bytes without the lead asking for four
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_count_reg != 2'd0 |-> ({1'b0, held_count_reg} < needed_reg))
        else $error("held byte count not below sequence length");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && byte_ch.stream_last) |=>
            (held_count_reg == 2'd0 && needed_reg == u8l1_pkg::LEN1))
        else $error("gather state not cleared after end of stream");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !char_ch.run_last) |=> char_ch.valid)
        else $error("result run broken before its last beat");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (res_cnt_reg > 2'd1) |-> !byte_ch.ready)
        else $error("byte accepted while flush results still pending");

endmodule

// ----- tb/sv/utf8_to_latin1_stream_tb.sv -----
// utf8_to_latin1_stream_tb: checks the UTF-8 to Latin-1 converter against its own byte decoder.
// A scoreboard predicts each Latin-1 beat from the accepted UTF-8 beats and checks every field.
// Depends on u8l1_pkg, u8l1_in_if, u8l1_out_if and utf8_to_latin1_stream.
module utf8_to_latin1_stream_tb;

    localparam int unsigned TOTAL_BYTES = 230;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned STALL_LIMIT = 2000;
    localparam int unsigned MAX_GAP     = 4;

    typedef struct packed {
        u8l1_pkg::byte_t ch;
        logic            run_last;
        logic            stream_done;
    } latin1_beat_t;

    class latin1_scoreboard;
        u8l1_pkg::byte_t held[3];
        int unsigned     held_cnt;
        int unsigned     need_len;
        latin1_beat_t    expected_q[$];
        int unsigned     err_cnt;
        int unsigned     chars_checked;
        int unsigned     streams_closed;
        int unsigned     flushes;

        function new();
            held_cnt       = 0;
            need_len       = 1;
            err_cnt        = 0;
            chars_checked  = 0;
            streams_closed = 0;
            flushes        = 0;
        endfunction

        function int unsigned lead_length(u8l1_pkg::byte_t c);
            if ((c & u8l1_pkg::LEAD2_MASK) == u8l1_pkg::LEAD2_CODE)
            begin
                return 2;
            end
            if ((c & u8l1_pkg::LEAD3_MASK) == u8l1_pkg::LEAD3_CODE)
            begin
                return 3;
            end
            if ((c & u8l1_pkg::LEAD4_MASK) == u8l1_pkg::LEAD4_CODE)
            begin
                return 4;
            end
            return 1;
        endfunction

        function u8l1_pkg::byte_t decode_seq(u8l1_pkg::byte_t g[4], int unsigned at,
                                             int unsigned n);
            int unsigned cp;
            case (n)
                2:       cp = {g[at][4:0], g[at+1][5:0]};
                3:       cp = {g[at][3:0], g[at+1][5:0], g[at+2][5:0]};
                4:       cp = u8l1_pkg::SUBST_CHAR;
                default: cp = g[at];
            endcase
            return (cp <= 255) ? u8l1_pkg::byte_t'(cp) : u8l1_pkg::SUBST_CHAR;
        endfunction

        function void note_byte(u8l1_pkg::byte_t b, logic last);
            u8l1_pkg::byte_t gathered[4];
            latin1_beat_t    outs[3];
            int unsigned     cnt;
            int unsigned     pos;
            int unsigned     n;
            int unsigned     k;
            if (held_cnt == 0)
            begin
                need_len = lead_length(b);
            end
            cnt = held_cnt;
            for (pos = 0; pos < cnt; pos++)
            begin
                gathered[pos] = held[pos];
            end
            gathered[cnt] = b;
            cnt++;
            if (cnt < need_len && !last)
            begin
                held[cnt-1] = b;
                held_cnt    = cnt;
                return;
            end
            if (cnt < need_len)
            begin
                flushes++;
            end
            if (last)
            begin
                streams_closed++;
            end
            // greedy reparse: a lead that does not fit goes out raw
            pos = 0;
            k   = 0;
            while (pos < cnt && k < 3)
            begin
                n = lead_length(gathered[pos]);
                if (pos + n > cnt)
                begin
                    n = 1;
                end
                outs[k].ch          = decode_seq(gathered, pos, n);
                outs[k].run_last    = 1'b0;
                outs[k].stream_done = 1'b0;
                k++;
                pos += n;
            end
            outs[k-1].run_last    = 1'b1;
            outs[k-1].stream_done = last;
            for (pos = 0; pos < k; pos++)
            begin
                expected_q = {expected_q, outs[pos]};
            end
            held_cnt = 0;
            need_len = 1;
        endfunction

        function void check_char(u8l1_pkg::byte_t c, logic rl, logic sd);
            latin1_beat_t want;
            if (expected_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: unexpected beat char=%02h run_last=%b stream_done=%b",
                         $time, c, rl, sd);
                return;
            end
            want = expected_q.pop_front();
            chars_checked++;
            if (c !== want.ch)
            begin
                err_cnt++;
                $display("%0t: latin1_char expected %02h got %02h", $time, want.ch, c);
            end
            if (rl !== want.run_last)
            begin
                err_cnt++;
                $display("%0t: run_last expected %b got %b", $time, want.run_last, rl);
            end
            if (sd !== want.stream_done)
            begin
                err_cnt++;
                $display("%0t: stream_done expected %b got %b", $time, want.stream_done, sd);
            end
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    u8l1_in_if  byte_ch();
    u8l1_out_if char_ch();

    latin1_scoreboard sb;

    bit          no_idle      = 1'b0;
    bit          hold_off_req = 1'b0;
    int unsigned holds_done   = 0;
    int unsigned sent_cnt     = 0;

    utf8_to_latin1_stream uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .char_ch (char_ch)
    );

    always #2 clk = ~clk;

    // both channels sampled at the same edge, input side first
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1)
            begin
                sb.note_byte(byte_ch.byte_in, byte_ch.stream_last);
            end
            if (char_ch.valid === 1'b1 && char_ch.ready === 1'b1)
            begin
                sb.check_char(char_ch.latin1_char, char_ch.run_last, char_ch.stream_done);
            end
        end
    end

    task automatic send_byte(input u8l1_pkg::byte_t b, input logic last);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.byte_in     <= b;
        byte_ch.stream_last <= last;
        @(posedge clk);
        while (byte_ch.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        sent_cnt++;
    endtask

    task automatic wait_drained();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin : char_sink
        int unsigned stall;
        char_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                stall        = HOLD_CYCLES;
                hold_off_req = 1'b0;
                holds_done++;
            end
            else if (no_idle)
            begin
                stall = 0;
            end
            else
            begin
                stall = $urandom_range(0, MAX_GAP);
            end
            if (stall > 0)
            begin
                char_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            char_ch.ready <= 1'b1;
            @(posedge clk);
            while (char_ch.valid !== 1'b1)
            begin
                @(posedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((byte_ch.valid === 1'b1 && byte_ch.ready === 1'b1) ||
                (char_ch.valid === 1'b1 && char_ch.ready === 1'b1))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
        end
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        // bit 8 marks the last byte of a stream
        logic [8:0]      directed_q[$] = '{
            9'h000, 9'h07F, 9'h0FF, 9'h080, 9'h0F8,
            9'h0C3, 9'h0A9,
            9'h0C4, 9'h080,
            9'h0E0, 9'h083, 9'h0BF,
            9'h0EF, 9'h0BF, 9'h1BF,
            9'h0F0, 9'h09F, 9'h098, 9'h080,
            9'h0F0, 9'h041, 9'h142,
            9'h1C3,
            9'h0E0, 9'h1C3
        };
        u8l1_pkg::byte_t seq_bytes[4];
        int unsigned     nb;
        int unsigned     kind;
        int unsigned     idx;
        logic            is_last;
        bit              hold_sent;

        sb        = new();
        hold_sent = 1'b0;
        byte_ch.valid       <= 1'b0;
        byte_ch.byte_in     <= '0;
        byte_ch.stream_last <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_q[i])
        begin
            send_byte(directed_q[i][7:0], directed_q[i][8]);
        end

        // sender pause until the output side has caught up
        wait_drained();

        while (sent_cnt < TOTAL_BYTES)
        begin
            no_idle = (sent_cnt >= 150 && sent_cnt < 190);
            if (!hold_sent && sent_cnt >= 90)
            begin
                // long receiver stall while single-byte beats keep coming
                hold_off_req = 1'b1;
                hold_sent    = 1'b1;
                for (idx = 0; idx < 24; idx++)
                begin
                    send_byte(u8l1_pkg::byte_t'($urandom_range(0, 127)), 1'b0);
                end
            end
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2:
                begin
                    nb           = 1;
                    seq_bytes[0] = u8l1_pkg::byte_t'($urandom_range(0, 127));
                end
                3, 4:
                begin
                    nb           = 2;
                    seq_bytes[0] = u8l1_pkg::LEAD2_CODE |
                                   u8l1_pkg::byte_t'($urandom_range(0, 1) ?
                                   $urandom_range(0, 3) : $urandom_range(0, 31));
                end
                5, 6:
                begin
                    nb           = 3;
                    seq_bytes[0] = u8l1_pkg::LEAD3_CODE |
                                   u8l1_pkg::byte_t'($urandom_range(0, 1) ?
                                   0 : $urandom_range(0, 15));
                end
                7:
                begin
                    nb           = 4;
                    seq_bytes[0] = u8l1_pkg::LEAD4_CODE |
                                   u8l1_pkg::byte_t'($urandom_range(0, 7));
                end
                8:
                begin
                    nb           = 1;
                    seq_bytes[0] = u8l1_pkg::byte_t'($urandom_range(0, 255));
                end
                default:
                begin
                    // up to three bytes of a 3- or 4-byte sequence, closed by end of stream
                    nb           = $urandom_range(1, 3);
                    seq_bytes[0] = $urandom_range(0, 1) ?
                                   (u8l1_pkg::LEAD4_CODE |
                                    u8l1_pkg::byte_t'($urandom_range(0, 7))) :
                                   (u8l1_pkg::LEAD3_CODE |
                                    u8l1_pkg::byte_t'($urandom_range(0, 15)));
                end
            endcase
            for (idx = 1; idx < nb; idx++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    seq_bytes[idx] = u8l1_pkg::byte_t'($urandom_range(0, 255));
                end
                else if (idx == 1 && $urandom_range(0, 1))
                begin
                    seq_bytes[idx] = 8'h80 | u8l1_pkg::byte_t'($urandom_range(0, 3));
                end
                else
                begin
                    seq_bytes[idx] = 8'h80 | u8l1_pkg::byte_t'($urandom_range(0, 63));
                end
            end
            for (idx = 0; idx < nb; idx++)
            begin
                is_last = (kind == 9 && idx == nb - 1) || ($urandom_range(0, 15) == 0);
                send_byte(seq_bytes[idx], is_last);
            end
        end
        no_idle = 1'b0;

        wait_drained();
        repeat (8) @(posedge clk);

        $display("run: %0d UTF-8 bytes sent, %0d Latin-1 beats checked", sent_cnt,
                 sb.chars_checked);
        $display("run: %0d streams closed, %0d mid-sequence flushes, %0d long stalls",
                 sb.streams_closed, sb.flushes, holds_done);
        if (sb.err_cnt == 0 && sb.expected_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- utf8_to_latin1_stream.f -----
rtl/u8l1_pkg.sv
rtl/u8l1_in_if.sv
rtl/u8l1_out_if.sv
rtl/utf8_to_latin1_stream.sv
tb/sv/utf8_to_latin1_stream_tb.sv
